### src/fca_pkg.sv
// Shared types and constants for the flow cache exporter.
// No dependencies.
package fca_pkg;

    localparam int FLOW_ENTRIES_DEF = 32;

    localparam logic [1:0] CFG_ACTIVE   = 2'd0;
    localparam logic [1:0] CFG_INACTIVE = 2'd1;
    localparam logic [1:0] CFG_MAXFLOWS = 2'd2;

    localparam logic [15:0] ACTIVE_RST   = 16'd60;
    localparam logic [15:0] INACTIVE_RST = 16'd10;
    localparam logic [5:0]  MAXFLOWS_RST = 6'd32;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] FIN_RST_MASK = 8'h05;
    localparam logic [9:0] MS_PER_S = 10'd1000;

    typedef struct packed {
        logic        valid;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [7:0]  tos;
        logic [31:0] packets;
        logic [31:0] octets;
        logic [31:0] first;
        logic [31:0] last;
        logic [7:0]  flags;
    } entry_t;

endpackage

### src/flow_cache_exporter_unit.sv
// Top level of the flow cache exporter: sequencer, head processing, output stage.
// Depends on fca_pkg and fca_cell.
//
// channel  dir  handshake                 payload
// s_       in   s_tvalid/s_tready         s_tdata packet, s_tuser mode
// m_       out  m_tvalid/m_tready         m_tdata flow record, m_tlast last_of_run
// cfg_     in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// Each packet passes through the idle accept, the timeout/lookup rotation, the update
// rotation and the finishing state, plus an eviction rotation when the oldest flow is
// evicted. A flush runs the sweep rotation, exporting every valid flow, then finishes.
// Reset clears all slot valid bits at once and the base time, and sets config defaults.
// A rotation step waits while a staged record is held and the full output is not taken.
module flow_cache_exporter_unit
    import fca_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // timestamp_ms, src_addr, dst_addr, src_port, dst_port, protocol,
    // type_of_service, tcp_flag_bits, octets
    input  logic [167:0] s_tdata,
    // mode
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // flow_src_addr, flow_dst_addr, flow_src_port, flow_dst_port, flow_protocol,
    // flow_tos, packet_count, octet_count, first_ms, last_ms, flow_flags
    output logic [247:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int IDXW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNTW = $clog2(FLOW_ENTRIES + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(FLOW_ENTRIES - 1);
    localparam logic [6:0] N7 = 7'(FLOW_ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SWEEP  = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_EVICT  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] active_reg, inactive_reg;
    logic [5:0]  maxf_reg;
    logic [31:0] base_reg;
    logic        base_set_reg;

    logic        flush_reg;
    logic [31:0] now_reg, act_ms_reg, ina_ms_reg;
    entry_t      new_reg;
    logic [IDXW-1:0] step_reg;
    logic        match_f_reg, free_f_reg, old_f_reg;
    logic [IDXW-1:0] match_i_reg, free_i_reg, old_i_reg;
    logic [31:0] old_first_reg;
    logic [CNTW-1:0] cnt_reg;

    entry_t      pend_reg;
    logic        pend_v_reg;
    logic        m_v_reg;
    entry_t      m_ent_reg;
    logic        m_last_reg;

    entry_t q [FLOW_ENTRIES];
    entry_t head, wr, emit_ent;
    logic   emit, go, can_push, shift_en;

    logic        match_f_nx, free_f_nx, old_f_nx;
    logic [IDXW-1:0] match_i_nx, free_i_nx, old_i_nx;
    logic [31:0] old_first_nx;
    logic [CNTW-1:0] cnt_nx;
    logic        tgt_ok, tgt_ins;
    logic [IDXW-1:0] tgt_i;
    logic [6:0]  limit;

    logic        in_acc;
    logic [31:0] in_ts, in_now;
    logic [7:0]  in_proto;

    genvar g;
    generate
        for (g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
            entry_t d;
            if (g == FLOW_ENTRIES - 1) begin : g_tail
                assign d = wr;
            end else begin : g_mid
                assign d = q[g+1];
            end
            fca_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d_in     (d),
                .q        (q[g])
            );
        end
    endgenerate

    assign head      = q[0];
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign in_ts     = s_tdata[31:0];
    assign in_proto  = s_tdata[135:128];
    assign in_now    = base_set_reg ? (in_ts - base_reg) : 32'd0;
    assign can_push  = !m_v_reg || m_tready;
    assign go        = !pend_v_reg || can_push;
    assign shift_en  = go && (state_reg == ST_SWEEP || state_reg == ST_UPDATE ||
                              state_reg == ST_EVICT);

    always_comb begin
        if (maxf_reg == 6'd0) begin
            limit = 7'd1;
        end else if ({1'b0, maxf_reg} > N7) begin
            limit = N7;
        end else begin
            limit = {1'b0, maxf_reg};
        end
    end

    assign tgt_ok  = match_f_reg || free_f_reg;
    assign tgt_ins = !match_f_reg;
    assign tgt_i   = match_f_reg ? match_i_reg : free_i_reg;

    always_comb begin
        wr           = head;
        emit         = 1'b0;
        emit_ent     = head;
        match_f_nx   = match_f_reg;
        match_i_nx   = match_i_reg;
        free_f_nx    = free_f_reg;
        free_i_nx    = free_i_reg;
        old_f_nx     = old_f_reg;
        old_i_nx     = old_i_reg;
        old_first_nx = old_first_reg;
        cnt_nx       = cnt_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                if (flush_reg) begin
                    emit = head.valid;
                end else begin
                    emit = head.valid && (((now_reg - head.first) > act_ms_reg) ||
                                          ((now_reg - head.last) > ina_ms_reg));
                end
                if (emit) begin
                    wr.valid = 1'b0;
                end
                if (wr.valid && !match_f_reg && wr.src == new_reg.src &&
                    wr.dst == new_reg.dst && wr.sport == new_reg.sport &&
                    wr.dport == new_reg.dport && wr.proto == new_reg.proto &&
                    wr.tos == new_reg.tos) begin
                    match_f_nx = 1'b1;
                    match_i_nx = step_reg;
                end
                if (!wr.valid && !free_f_reg) begin
                    free_f_nx = 1'b1;
                    free_i_nx = step_reg;
                end
            end
            ST_UPDATE: begin
                if (tgt_ok && step_reg == tgt_i) begin
                    if (tgt_ins) begin
                        wr = new_reg;
                    end else begin
                        wr.packets = head.packets + 32'd1;
                        wr.octets  = head.octets + new_reg.octets;
                        wr.last    = new_reg.last;
                        wr.flags   = head.flags | new_reg.flags;
                    end
                    emit_ent = wr;
                    if ((wr.flags & FIN_RST_MASK) != 8'd0) begin
                        emit     = 1'b1;
                        wr.valid = 1'b0;
                    end
                end
                if (wr.valid) begin
                    cnt_nx = cnt_reg + CNTW'(1);
                    if (!old_f_reg || wr.first < old_first_reg) begin
                        old_f_nx     = 1'b1;
                        old_i_nx     = step_reg;
                        old_first_nx = wr.first;
                    end
                end
            end
            ST_EVICT: begin
                if (old_f_reg && step_reg == old_i_reg && head.valid) begin
                    emit     = 1'b1;
                    wr.valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (go && step_reg == LAST_IDX) begin
                    state_next = flush_reg ? ST_FINISH : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (go && step_reg == LAST_IDX) begin
                    if (old_f_nx && 7'(cnt_nx) >= limit) begin
                        state_next = ST_EVICT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_EVICT: begin
                if (go && step_reg == LAST_IDX) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!pend_v_reg || can_push) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ACTIVE:   active_reg   <= cfg_data;
                CFG_INACTIVE: inactive_reg <= cfg_data;
                CFG_MAXFLOWS: maxf_reg     <= cfg_data[5:0];
                default: begin
                end
            endcase
        end

        if (in_acc) begin
            flush_reg     <= s_tuser;
            step_reg      <= '0;
            match_f_reg   <= 1'b0;
            free_f_reg    <= 1'b0;
            old_f_reg     <= 1'b0;
            cnt_reg       <= '0;
            act_ms_reg    <= 32'(active_reg) * 32'(MS_PER_S);
            ina_ms_reg    <= 32'(inactive_reg) * 32'(MS_PER_S);
            if (!s_tuser) begin
                if (!base_set_reg) begin
                    base_reg     <= in_ts;
                    base_set_reg <= 1'b1;
                end
                now_reg          <= in_now;
                new_reg.valid    <= 1'b1;
                new_reg.src      <= s_tdata[63:32];
                new_reg.dst      <= s_tdata[95:64];
                new_reg.sport    <= (in_proto == PROTO_ICMP) ? 16'd0 : s_tdata[111:96];
                new_reg.dport    <= (in_proto == PROTO_ICMP) ? 16'd0 : s_tdata[127:112];
                new_reg.proto    <= in_proto;
                new_reg.tos      <= s_tdata[143:136];
                new_reg.flags    <= (in_proto == PROTO_TCP) ? s_tdata[151:144] : 8'd0;
                new_reg.octets   <= {16'd0, s_tdata[167:152]};
                new_reg.packets  <= 32'd1;
                new_reg.first    <= in_now;
                new_reg.last     <= in_now;
            end
        end else if (shift_en) begin
            step_reg      <= (step_reg == LAST_IDX) ? '0 : step_reg + IDXW'(1);
            match_f_reg   <= match_f_nx;
            match_i_reg   <= match_i_nx;
            free_f_reg    <= free_f_nx;
            free_i_reg    <= free_i_nx;
            old_f_reg     <= old_f_nx;
            old_i_reg     <= old_i_nx;
            old_first_reg <= old_first_nx;
            cnt_reg       <= cnt_nx;
        end

        if (m_v_reg && m_tready) begin
            m_v_reg <= 1'b0;
        end
        if (shift_en && emit) begin
            if (pend_v_reg) begin
                m_v_reg    <= 1'b1;
                m_ent_reg  <= pend_reg;
                m_last_reg <= 1'b0;
            end
            pend_reg   <= emit_ent;
            pend_v_reg <= 1'b1;
        end else if (state_reg == ST_FINISH && pend_v_reg && can_push) begin
            m_v_reg    <= 1'b1;
            m_ent_reg  <= pend_reg;
            m_last_reg <= 1'b1;
            pend_v_reg <= 1'b0;
        end

        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= ACTIVE_RST;
            inactive_reg <= INACTIVE_RST;
            maxf_reg     <= MAXFLOWS_RST;
            base_reg     <= 32'd0;
            base_set_reg <= 1'b0;
            pend_v_reg   <= 1'b0;
            m_v_reg      <= 1'b0;
            step_reg     <= '0;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_ent_reg.flags, m_ent_reg.last, m_ent_reg.first,
                       m_ent_reg.octets, m_ent_reg.packets, m_ent_reg.tos,
                       m_ent_reg.proto, m_ent_reg.dport, m_ent_reg.sport,
                       m_ent_reg.dst, m_ent_reg.src};

`ifndef SYNTH
    a_ready_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_v_reg)
        else $error("input ready with a staged record");
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && !pend_v_reg) |=> state_reg == ST_IDLE)
        else $error("finish did not return to idle");
    a_push_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && pend_v_reg && can_push) |=> (m_tvalid && m_tlast))
        else $error("final record not marked last");
`endif

endmodule

### src/fca_cell.sv
// One flow table slot in the rotating chain of cells.
// Depends on fca_pkg.
module fca_cell
    import fca_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   shift_en,
    input  entry_t d_in,
    output entry_t q
);

    entry_t ent_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            ent_reg <= d_in;
        end
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
        end
    end

    assign q = ent_reg;

endmodule

### bench/flow_cache_exporter_unit_tb.sv
// Testbench for flow_cache_exporter_unit: directed table plus random packet traffic,
// checked record by record against a behavioral flow table. Depends on fca_pkg.
`timescale 1ns / 100ps

module flow_cache_exporter_unit_tb;
    import fca_pkg::*;

    localparam int  SLOTS       = 32;
    localparam int  DRAIN_WAIT  = 200;
    localparam int  STALL_LIMIT = 20000;
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] FLAG_FIN  = 8'h01;
    localparam logic [7:0] FLAG_RST  = 8'h04;

    typedef struct {
        logic        mode;
        logic [31:0] ts;
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0]  proto;
        logic [7:0]  tos;
        logic [7:0]  fl;
        logic [15:0] oct;
    } pkt_t;

    typedef struct {
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0]  proto;
        logic [7:0]  tos;
        logic [31:0] packets;
        logic [31:0] octets;
        logic [31:0] first;
        logic [31:0] last;
        logic [7:0]  flags;
        logic        last_run;
    } flow_rec_t;

    typedef struct {
        pkt_t p;
        int   known_cnt;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [247:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = CFG_ACTIVE;
    logic [15:0]  cfg_data = '0;

    flow_cache_exporter_unit dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // flow table mirror
    flow_rec_t   tbl [SLOTS];
    bit          tbl_valid [SLOTS];
    logic [31:0] base_ms;
    bit          base_set;
    logic [15:0] act_s, ina_s;
    logic [5:0]  max_fl;

    flow_rec_t pending_flows[$];
    int  errors = 0;
    int  cnt_errors = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    int  hold_cnt = 0;
    int  hold_taken = 0;

    task automatic export_slot(int i, ref flow_rec_t batch[$]);
        flow_rec_t r;
        r = tbl[i];
        r.last_run = 1'b0;
        batch.push_back(r);
        tbl_valid[i] = 1'b0;
    endtask

    task automatic predict_request(pkt_t p, output int n);
        flow_rec_t batch[$];
        logic [31:0] now_ms, act_ms, ina_ms;
        logic [7:0]  fl;
        logic [15:0] sp, dp;
        int hit, cnt, lim, old;
        hit = -1;
        if (p.mode == MODE_FLUSH) begin
            for (int i = 0; i < SLOTS; i++)
                if (tbl_valid[i]) export_slot(i, batch);
        end else begin
            if (!base_set) begin
                base_ms = p.ts;
                base_set = 1'b1;
            end
            now_ms = p.ts - base_ms;
            sp = p.sp;
            dp = p.dp;
            fl = p.fl;
            if (p.proto == PROTO_ICMP) begin
                sp = '0;
                dp = '0;
            end
            if (p.proto != PROTO_TCP) fl = '0;
            act_ms = 32'(act_s) * 32'd1000;
            ina_ms = 32'(ina_s) * 32'd1000;
            for (int i = 0; i < SLOTS; i++)
                if (tbl_valid[i] && ((now_ms - tbl[i].first) > act_ms ||
                                     (now_ms - tbl[i].last) > ina_ms))
                    export_slot(i, batch);
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && tbl_valid[i] && tbl[i].sa == p.sa && tbl[i].da == p.da &&
                    tbl[i].sp == sp && tbl[i].dp == dp && tbl[i].proto == p.proto &&
                    tbl[i].tos == p.tos)
                    hit = i;
            if (hit >= 0) begin
                tbl[hit].packets += 32'd1;
                tbl[hit].octets  += 32'(p.oct);
                tbl[hit].last     = now_ms;
                tbl[hit].flags   |= fl;
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && !tbl_valid[i]) hit = i;
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b1;
                    tbl[hit] = '{p.sa, p.da, sp, dp, p.proto, p.tos, 32'd1, 32'(p.oct),
                                 now_ms, now_ms, fl, 1'b0};
                end
            end
            if (hit >= 0 && (tbl[hit].flags & FIN_RST_MASK) != 0) export_slot(hit, batch);
            lim = (max_fl == 0) ? 1 : (int'(max_fl) > SLOTS ? SLOTS : int'(max_fl));
            cnt = 0;
            for (int i = 0; i < SLOTS; i++) cnt += int'(tbl_valid[i]);
            if (cnt >= lim) begin
                old = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_valid[i] && (old < 0 || tbl[i].first < tbl[old].first)) old = i;
                if (old >= 0) export_slot(old, batch);
            end
        end
        n = batch.size();
        if (n > 0) batch[n-1].last_run = 1'b1;
        foreach (batch[k]) pending_flows.push_back(batch[k]);
    endtask

    task automatic send_request(pkt_t p, int known_cnt);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = p.mode;
        s_tdata  = {p.oct, p.fl, p.tos, p.proto, p.dp, p.sp, p.da, p.sa, p.ts};
        do @(posedge aclk); while (!s_tready);
        predict_request(p, n);
        if (known_cnt >= 0 && n != known_cnt) begin
            $display("%0t: record count expected %0d actual %0d", $time, known_cnt, n);
            cnt_errors++;
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_flows.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ACTIVE:   act_s  = val;
            CFG_INACTIVE: ina_s  = val;
            default:      max_fl = val[5:0];
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(logic [15:0] a, logic [15:0] b, logic [15:0] m);
        wait_drained();
        write_reg(CFG_ACTIVE, a);
        write_reg(CFG_INACTIVE, b);
        write_reg(CFG_MAXFLOWS, m);
    endtask

    function automatic pkt_t mk(logic md, logic [31:0] ts, logic [31:0] sa, logic [31:0] da,
                                logic [15:0] sp, logic [15:0] dp, logic [7:0] pr,
                                logic [7:0] tos, logic [7:0] fl, logic [15:0] oct);
        pkt_t p;
        p = '{md, ts, sa, da, sp, dp, pr, tos, fl, oct};
        return p;
    endfunction

    // random traffic over a small key pool so flows get hit repeatedly
    task automatic random_phase(int items);
        pkt_t pool[10];
        pkt_t p;
        logic [7:0] protos[4];
        logic [31:0] ts;
        protos = '{PROTO_ICMP, PROTO_TCP, PROTO_UDP, 8'h00};
        ts = base_set ? base_ms + $urandom_range(0, 100000) : $urandom;
        foreach (pool[k]) begin
            protos[3] = 8'($urandom);
            pool[k] = mk(MODE_PACKET, 0, $urandom, $urandom, 16'($urandom), 16'($urandom),
                         protos[$urandom_range(0, 3)], 8'($urandom), 0, 0);
        end
        for (int k = 0; k < items; k++) begin
            case ($urandom_range(0, 15))
                0:       ts = $urandom;
                1, 2:    ts += $urandom_range(0, 80000);
                default: ts += $urandom_range(0, 2000);
            endcase
            if ($urandom_range(0, 4) == 0) begin
                protos[3] = 8'($urandom);
                p = mk(MODE_PACKET, 0, $urandom, $urandom, 16'($urandom), 16'($urandom),
                       protos[$urandom_range(0, 3)], 8'($urandom), 0, 0);
            end else begin
                p = pool[$urandom_range(0, 9)];
            end
            p.ts  = ts;
            p.oct = 16'($urandom);
            p.fl  = 8'($urandom) & ~(FLAG_FIN | FLAG_RST);
            if ($urandom_range(0, 7) == 0) p.fl |= ($urandom_range(0, 1) ? FLAG_FIN : FLAG_RST);
            if ($urandom_range(0, 3) == 0) p.fl = 8'($urandom);
            p.mode = ($urandom_range(0, 24) == 0) ? MODE_FLUSH : MODE_PACKET;
            if (k == 10 && !calm) hold_cnt++;
            send_request(p, -1);
        end
    endtask

    // receiver
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_taken != hold_cnt) begin
                hold_taken = hold_cnt;
                m_tready = 1'b0;
                repeat (400) @(negedge aclk);
                m_tready = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s expected %h actual %h", $time, name, e, a);
            errors++;
        end
    endtask

    // checker
    always @(posedge aclk) begin
        flow_rec_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_flows.size() == 0) begin
                $display("%0t: unexpected record expected none actual %h", $time, m_tdata);
                errors++;
            end else begin
                e = pending_flows.pop_front();
                cmp("src_addr", e.sa, m_tdata[31:0]);
                cmp("dst_addr", e.da, m_tdata[63:32]);
                cmp("src_port", 32'(e.sp), 32'(m_tdata[79:64]));
                cmp("dst_port", 32'(e.dp), 32'(m_tdata[95:80]));
                cmp("protocol", 32'(e.proto), 32'(m_tdata[103:96]));
                cmp("tos", 32'(e.tos), 32'(m_tdata[111:104]));
                cmp("packets", e.packets, m_tdata[143:112]);
                cmp("octets", e.octets, m_tdata[175:144]);
                cmp("first_ms", e.first, m_tdata[207:176]);
                cmp("last_ms", e.last, m_tdata[239:208]);
                cmp("flags", 32'(e.flags), 32'(m_tdata[247:240]));
                cmp("tlast", 32'(e.last_run), 32'(m_tlast));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    row_t rows[$];

    initial begin
        act_s = ACTIVE_RST;
        ina_s = INACTIVE_RST;
        max_fl = MAXFLOWS_RST;
        base_set = 1'b0;
        base_ms = '0;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

        rows.push_back('{mk(MODE_FLUSH, 32'hFFFF_FFFF, '1, '1, '1, '1, '1, '1, '1, '1), 0});
        rows.push_back('{mk(MODE_PACKET, 1000, 32'h0A000001, 32'h0A000002, 1234, 80,
                            PROTO_TCP, 0, 8'h02, 60), 0});
        rows.push_back('{mk(MODE_PACKET, 1500, 32'h0A000001, 32'h0A000002, 1234, 80,
                            PROTO_TCP, 0, FLAG_FIN, 40), 1});
        rows.push_back('{mk(MODE_PACKET, 1600, 32'hC0A80001, 32'hC0A80002, 777, 888,
                            PROTO_ICMP, 8'h10, 8'hFF, 84), 0});
        rows.push_back('{mk(MODE_PACKET, 1700, 32'hC0A80001, 32'hC0A80002, 0, 0,
                            PROTO_ICMP, 8'h10, 8'h00, 84), 0});
        rows.push_back('{mk(MODE_PACKET, 1800, 32'h01020304, 32'h05060708, 53, 53,
                            PROTO_UDP, 0, 8'hFF, 100), 0});
        rows.push_back('{mk(MODE_PACKET, 1900, 32'h01020304, 32'h05060708, 53, 53,
                            8'd47, 8'hB8, 8'h05, 0), 0});
        rows.push_back('{mk(MODE_PACKET, 30000, 32'h0B000001, 32'h0B000002, 5, 6,
                            PROTO_TCP, 0, FLAG_RST, 1), -1});
        rows.push_back('{mk(MODE_PACKET, 30001, '1, '1, '1, '1, PROTO_TCP, '1, 8'hFA, '1), 0});
        rows.push_back('{mk(MODE_PACKET, 30002, '1, '1, '1, '1, PROTO_TCP, '1, 8'hFA, '1), 0});
        rows.push_back('{mk(MODE_PACKET, 30003, '0, '0, '0, '0, 8'h00, '0, '0, '0), 0});
        rows.push_back('{mk(MODE_PACKET, 0, '0, '0, '0, '0, 8'hFF, '0, '0, '0), -1});
        rows.push_back('{mk(MODE_PACKET, 90000, 32'h55555555, 32'hAAAAAAAA, 16'h5555,
                            16'hAAAA, PROTO_UDP, 8'h55, 0, 16'hAAAA), -1});
        rows.push_back('{mk(MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0), -1});
        rows.push_back('{mk(MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0});

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (rows[k]) send_request(rows[k].p, rows[k].known_cnt);

        set_regs(1, 1, 4);
        random_phase(30);
        set_regs(16'hFFFF, 16'hFFFF, 6'd63);
        random_phase(40);
        set_regs(5, 2, 0);
        random_phase(25);
        set_regs(30, 16'hFFFF, 8);
        calm = 1'b1;
        random_phase(59);
        send_request(mk(MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0), -1);

        wait_drained();
        if (errors == 0 && cnt_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
